FILE: rtl/gcode_emergency_command_detector_macros.svh
// Assertion macros used by the detector's top-level RTL file.
`ifndef GCODE_EMERGENCY_COMMAND_DETECTOR_MACROS_SVH
`define GCODE_EMERGENCY_COMMAND_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GCED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("detector assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GCED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("detector assertion failed");

`endif

FILE: rtl/gced_pkg.sv
// Package with the types and character codes of the urgent-command detector.
`default_nettype none

package gced_pkg;

  // One received byte.
  typedef logic [7:0] char_t;

  // Reported command code.
  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_NONE  = 2'd0;
  localparam cmd_t CMD_M108  = 2'd1;
  localparam cmd_t CMD_M112  = 2'd2;
  localparam cmd_t CMD_M410  = 2'd3;

  // ASCII characters the parser looks for.
  localparam char_t CHAR_NL    = 8'h0A;
  localparam char_t CHAR_SP    = 8'h20;
  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_0     = 8'h30;
  localparam char_t CHAR_1     = 8'h31;
  localparam char_t CHAR_2     = 8'h32;
  localparam char_t CHAR_4     = 8'h34;
  localparam char_t CHAR_8     = 8'h38;
  localparam char_t CHAR_9     = 8'h39;
  localparam char_t CHAR_M     = 8'h4D;
  localparam char_t CHAR_N     = 8'h4E;

  // Line parser phases, one-hot.
  typedef enum logic [11:0] {
    PH_START = 12'b0000_0000_0001,
    PH_NUM   = 12'b0000_0000_0010,
    PH_M     = 12'b0000_0000_0100,
    PH_M1    = 12'b0000_0000_1000,
    PH_M10   = 12'b0000_0001_0000,
    PH_M11   = 12'b0000_0010_0000,
    PH_M4    = 12'b0000_0100_0000,
    PH_M41   = 12'b0000_1000_0000,
    PH_M108  = 12'b0001_0000_0000,
    PH_M112  = 12'b0010_0000_0000,
    PH_M410  = 12'b0100_0000_0000,
    PH_SKIP  = 12'b1000_0000_0000
  } phase_t;

  // Parser decision for one byte.
  typedef struct packed {
    phase_t phase;
    cmd_t   found;
  } parse_res_t;

endpackage

`default_nettype wire

FILE: rtl/gced_if.sv
// Valid/ready channel interfaces for received bytes and reported commands.
`default_nettype none

interface gced_char_if;
  import gced_pkg::*;

  logic  valid;
  logic  ready;
  char_t rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface gced_cmd_if;
  import gced_pkg::*;

  logic valid;
  logic ready;
  cmd_t command_found;

  modport source (output valid, output command_found, input ready);
  modport sink (input valid, input command_found, output ready);
endinterface

`default_nettype wire

FILE: rtl/gced_parser.sv
// Next-phase and command decode of the line parser for one received byte.
`default_nettype none

module gced_parser (
  input  gced_pkg::phase_t     phase,
  input  gced_pkg::char_t      rx_char,
  output gced_pkg::parse_res_t res
);
  import gced_pkg::*;

  logic is_digit;
  logic is_nl;
  logic is_sp;

  assign is_digit = (rx_char >= CHAR_0) && (rx_char <= CHAR_9);
  assign is_nl    = (rx_char == CHAR_NL);
  assign is_sp    = (rx_char == CHAR_SP);

  // Phase transition table; a command is reported only on the newline after a full code.
  always_comb begin
    res.phase = phase;
    res.found = CMD_NONE;
    case (phase)
      PH_START: begin
        if (is_sp) begin
          res.phase = PH_START;
        end else if (rx_char == CHAR_N) begin
          res.phase = PH_NUM;
        end else if (rx_char == CHAR_M) begin
          res.phase = PH_M;
        end else begin
          res.phase = PH_SKIP;
        end
      end
      PH_NUM: begin
        if (is_digit || is_sp || (rx_char == CHAR_MINUS)) begin
          res.phase = PH_NUM;
        end else if (rx_char == CHAR_M) begin
          res.phase = PH_M;
        end else begin
          res.phase = PH_SKIP;
        end
      end
      PH_M: begin
        if (is_sp) begin
          res.phase = PH_M;
        end else if (rx_char == CHAR_1) begin
          res.phase = PH_M1;
        end else if (rx_char == CHAR_4) begin
          res.phase = PH_M4;
        end else begin
          res.phase = PH_SKIP;
        end
      end
      PH_M1: begin
        if (rx_char == CHAR_0) begin
          res.phase = PH_M10;
        end else if (rx_char == CHAR_1) begin
          res.phase = PH_M11;
        end else begin
          res.phase = PH_SKIP;
        end
      end
      PH_M10: begin
        res.phase = (rx_char == CHAR_8) ? PH_M108 : PH_SKIP;
      end
      PH_M11: begin
        res.phase = (rx_char == CHAR_2) ? PH_M112 : PH_SKIP;
      end
      PH_M4: begin
        res.phase = (rx_char == CHAR_1) ? PH_M41 : PH_SKIP;
      end
      PH_M41: begin
        res.phase = (rx_char == CHAR_0) ? PH_M410 : PH_SKIP;
      end
      PH_M108: begin
        if (is_nl) begin
          res.phase = PH_START;
          res.found = CMD_M108;
        end
      end
      PH_M112: begin
        if (is_nl) begin
          res.phase = PH_START;
          res.found = CMD_M112;
        end
      end
      PH_M410: begin
        if (is_nl) begin
          res.phase = PH_START;
          res.found = CMD_M410;
        end
      end
      PH_SKIP: begin
        if (is_nl) begin
          res.phase = PH_START;
        end
      end
      default: begin
        // A corrupted phase waits for the end of the line, then restarts.
        if (is_nl) begin
          res.phase = PH_START;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/gcode_emergency_command_detector.sv
// Urgent G-code command detector: byte register, line parser and result register.
//
// Usage: received bytes enter on in_if (valid/ready, field rx_char); for every
// byte exactly one result leaves on out_if (valid/ready, field command_found).
// command_found is 0 for ordinary bytes, and 1 (M108), 2 (M112) or 3 (M410) on
// the newline that ends a line holding that urgent code.
// Path: an accepted byte is registered in the byte register, decoded there by
// the parser, and its result is registered in the result register for out_if.
// Throughput: one byte per cycle while the receiver keeps taking results; the
// parser phase updates in the decode stage as each byte moves on.
// Reset (rst_n low, synchronous): both stages empty, parser back at line start.
// Receiver stall: a held result stays in the result register; one more byte
// may wait in the byte register, after which in_if.ready drops until the
// receiver takes the held result.
`default_nettype none
`include "gcode_emergency_command_detector_macros.svh"

module gcode_emergency_command_detector (
  input  wire          clk,
  input  wire          rst_n,
  gced_char_if.sink    in_if,
  gced_cmd_if.source   out_if
);
  import gced_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  char_t      s1_char_r;
  char_t      s1_char_nxt;
  phase_t     phase_r;
  phase_t     phase_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  cmd_t       out_found_r;
  cmd_t       out_found_nxt;
  logic       s1_adv;
  logic       in_acc;
  parse_res_t res;

  // Stage handshakes: a byte moves on whenever the result register is free.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;

  gced_parser u_parser (
    .phase   (phase_r),
    .rx_char (s1_char_r),
    .res     (res)
  );

  // Next values of the byte stage, parser phase and result stage.
  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    s1_char_nxt   = in_acc ? in_if.rx_char : s1_char_r;
    phase_nxt     = s1_adv ? res.phase : phase_r;
    out_valid_nxt = s1_adv || (out_valid_r && !out_if.ready);
    out_found_nxt = s1_adv ? res.found : out_found_r;
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_START;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_char_r   <= s1_char_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.command_found = out_found_r;

  // A command is reported only for a newline byte.
  `GCED_ASSERT_IMP(a_found_on_nl, s1_adv && (res.found != CMD_NONE), s1_char_r == CHAR_NL)
  // The phase only moves when a byte is decoded.
  `GCED_ASSERT_NXT(a_phase_hold, !s1_adv, $stable(phase_r))
  // A decoded byte always lands in the result register.
  `GCED_ASSERT_NXT(a_result_lands, s1_adv, out_valid_r)
  // A newline while skipping returns the parser to line start.
  `GCED_ASSERT_NXT(a_skip_ends, s1_adv && (phase_r == PH_SKIP) && (s1_char_r == CHAR_NL),
                   phase_r == PH_START)

endmodule

`default_nettype wire

FILE: sim/gced_checker.sv
// Checker that predicts and compares the urgent-command detector's results.
`timescale 1ns / 100ps

module gced_checker (
  input  logic clk,
  input  logic rst_n,
  gced_char_if char_mon,
  gced_cmd_if  cmd_mon,
  output int   n_errors,
  output int   n_pending,
  output int   n_checked,
  output int   n_urgent
);
  import gced_pkg::*;

  // Predicted parser phase and the commands still owed by the block.
  phase_t line_phase;
  cmd_t   owed_cmd_q[$];

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    n_errors++;
  endtask

  // Next parser phase and reported command for one received byte.
  function automatic parse_res_t next_parse(input phase_t ph, input char_t c);
    parse_res_t r;
    r.phase = ph;
    r.found = CMD_NONE;
    case (ph)
      PH_START: begin
        if (c == CHAR_SP) r.phase = ph;
        else if (c == CHAR_N) r.phase = PH_NUM;
        else if (c == CHAR_M) r.phase = PH_M;
        else r.phase = PH_SKIP;
      end
      PH_NUM: begin
        if ((c >= CHAR_0 && c <= CHAR_9) || c == CHAR_MINUS || c == CHAR_SP) r.phase = ph;
        else if (c == CHAR_M) r.phase = PH_M;
        else r.phase = PH_SKIP;
      end
      PH_M: begin
        if (c == CHAR_SP) r.phase = ph;
        else if (c == CHAR_1) r.phase = PH_M1;
        else if (c == CHAR_4) r.phase = PH_M4;
        else r.phase = PH_SKIP;
      end
      PH_M1: begin
        if (c == CHAR_0) r.phase = PH_M10;
        else if (c == CHAR_1) r.phase = PH_M11;
        else r.phase = PH_SKIP;
      end
      PH_M10: r.phase = (c == CHAR_8) ? PH_M108 : PH_SKIP;
      PH_M11: r.phase = (c == CHAR_2) ? PH_M112 : PH_SKIP;
      PH_M4:  r.phase = (c == CHAR_1) ? PH_M41 : PH_SKIP;
      PH_M41: r.phase = (c == CHAR_0) ? PH_M410 : PH_SKIP;
      PH_SKIP: begin
        if (c == CHAR_NL) r.phase = PH_START;
      end
      default: begin
        // A complete code fires on the newline that ends its line.
        if (c == CHAR_NL) begin
          if (ph == PH_M108) r.found = CMD_M108;
          else if (ph == PH_M112) r.found = CMD_M112;
          else if (ph == PH_M410) r.found = CMD_M410;
          r.phase = PH_START;
        end
      end
    endcase
    return r;
  endfunction

  // Compare each taken result with the oldest prediction, then predict the next item.
  always @(posedge clk) begin : track
    parse_res_t decision;
    cmd_t       want;
    if (!rst_n) begin
      line_phase = PH_START;
      owed_cmd_q.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (owed_cmd_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no item outstanding",
                                    cmd_mon.command_found));
        end else begin
          want = owed_cmd_q.pop_front();
          n_checked++;
          if (want != CMD_NONE) n_urgent++;
          if (cmd_mon.command_found !== want)
            report_mismatch($sformatf("command_found %0d, predicted %0d",
                                      cmd_mon.command_found, want));
        end
      end
      if (char_mon.valid && char_mon.ready) begin
        decision = next_parse(line_phase, char_mon.rx_char);
        line_phase = decision.phase;
        owed_cmd_q.push_back(decision.found);
      end
    end
    n_pending = owed_cmd_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// Top of the detector testbench: clock, reset, byte stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
  import gced_pkg::*;

  localparam int TARGET_BYTES = 1950;

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   n_sent;
  int   n_lines;
  int   n_errors, n_pending, n_checked, n_urgent;
  char_t line_buf[$];

  gced_char_if char_ch ();
  gced_cmd_if  cmd_ch ();

  gcode_emergency_command_detector dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (char_ch),
    .out_if(cmd_ch)
  );

  gced_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .char_mon (char_ch),
    .cmd_mon  (cmd_ch),
    .n_errors (n_errors),
    .n_pending(n_pending),
    .n_checked(n_checked),
    .n_urgent (n_urgent)
  );

  // Clock with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one byte after a random gap and hold it until the block takes it.
  task automatic send_byte(input char_t b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      char_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_ch.valid   = 1'b1;
    char_ch.rx_char = b;
    do @(posedge clk); while (!char_ch.ready);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(char_t'(s[i]));
  endtask

  // Well-formed urgent command line with random spacing, number and tail.
  task automatic put_command_line();
    int r;
    repeat ($urandom_range(0, 2)) line_buf.push_back(CHAR_SP);
    if ($urandom_range(0, 2) == 0) begin
      line_buf.push_back(CHAR_N);
      repeat ($urandom_range(0, 4)) begin
        r = $urandom_range(0, 11);
        if (r < 10) line_buf.push_back(char_t'(CHAR_0 + r));
        else if (r == 10) line_buf.push_back(CHAR_MINUS);
        else line_buf.push_back(CHAR_SP);
      end
    end
    line_buf.push_back(CHAR_M);
    repeat ($urandom_range(0, 1)) line_buf.push_back(CHAR_SP);
    case ($urandom_range(0, 2))
      0: begin
        line_buf.push_back(CHAR_1); line_buf.push_back(CHAR_0); line_buf.push_back(CHAR_8);
      end
      1: begin
        line_buf.push_back(CHAR_1); line_buf.push_back(CHAR_1); line_buf.push_back(CHAR_2);
      end
      default: begin
        line_buf.push_back(CHAR_4); line_buf.push_back(CHAR_1); line_buf.push_back(CHAR_0);
      end
    endcase
    repeat ($urandom_range(0, 3)) line_buf.push_back(char_t'($urandom_range(8'h20, 8'h7E)));
    line_buf.push_back(CHAR_NL);
  endtask

  // Build one random line and send it.
  task automatic send_line();
    int kind;
    int pos;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      put_command_line();
      // Some command lines get broken: a stray byte, an early newline or a space.
      if (kind >= 58) begin
        pos = $urandom_range(0, line_buf.size() - 2);
        case ($urandom_range(0, 2))
          0: line_buf[pos] = char_t'($urandom_range(0, 255));
          1: line_buf[pos] = CHAR_NL;
          default: line_buf.insert(pos, CHAR_SP);
        endcase
      end
    end else if (kind < 87) begin
      repeat ($urandom_range(1, 10)) line_buf.push_back(char_t'($urandom_range(8'h21, 8'h7E)));
      line_buf.push_back(CHAR_NL);
    end else if (kind < 97) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(char_t'($urandom_range(0, 255)));
    end else begin
      line_buf.push_back(CHAR_NL);
    end
    no_gaps = ($urandom_range(0, 7) == 0);
    foreach (line_buf[i]) send_byte(line_buf[i]);
    n_lines++;
  endtask

  // Result side: random stalls on ready.
  initial begin : result_stall
    int stall;
    stall = 0;
    cmd_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        cmd_ch.ready = 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        cmd_ch.ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Reset, directed lines, random lines, drain and verdict.
  initial begin
    rst_n = 1'b0;
    no_gaps = 1'b0;
    n_sent = 0;
    n_lines = 0;
    char_ch.valid = 1'b0;
    char_ch.rx_char = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // M108 and M410, with a tail, a line number, and spaces where they are allowed.
    send_text("M108;\n");
    send_text(" N-9 M 410\n");
    // Newline inside a partial code: the next line is ignored, extreme bytes included.
    send_text("M1\n");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("M112\n");

    while (n_sent < TARGET_BYTES) send_line();

    @(negedge clk);
    char_ch.valid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d bytes in %0d lines; %0d results checked, %0d urgent commands seen.",
             n_sent, n_lines, n_checked, n_urgent);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
